@@ rtl/core/vla_pkg.sv @@
// shared types and constants for the vector loss and accuracy block
`default_nettype none

package vla_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int MAG_W      = SAMPLE_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SIGN_W     = 2;
    localparam int SQ_OUT_W   = 42;
    localparam int ABS_OUT_W  = 26;
    localparam int IN_DATA_W  = 2 * SAMPLE_W;
    localparam int OUT_DATA_W = 88;

    // largest possible magnitude of one difference
    localparam longint unsigned DIFF_MAX = (64'd1 << SAMPLE_W) - 64'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [SIGN_W-1:0]   sign_t;

    localparam sign_t SIGN_LESS    = 2'sb11;
    localparam sign_t SIGN_EQUAL   = 2'sb00;
    localparam sign_t SIGN_GREATER = 2'sb01;

    // payload passed from the compare stage to the accumulate stage
    typedef struct packed {
        diff_t              difference;
        sign_t              sign_compare;
        logic [MAG_W-1:0]   magnitude;
        logic [SQ_W-1:0]    square;
        logic               last;
        logic               argmax_match;
    } stage_t;

endpackage

`default_nettype wire

@@ rtl/core/vector_loss_and_accuracy.sv @@
// Accepts one prediction/label pair per clock unless m_tready stalls the output. Each
// request yields one result that passes the input, compare and output stage registers
// on its way to the output: the difference and its sign. Across a vector the block
// keeps saturating sums of squared and absolute error and the first-maximum
// argmax of both streams; the request marked last returns the totals and the
// argmax match flag and clears the running state. Throughput is one request
// per cycle when the output is not stalled, set by the single add-and-saturate
// accumulator loop in the last stage; the squarer sits in the stage before it.
// Elements beyond MAX_ELEMENTS share the last index and the sums saturate at
// their full-vector maxima.
`default_nettype none

module vector_loss_and_accuracy
    import vla_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pred_value [15:0], label_value [31:16]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // difference [16:0], sign_compare [18:17], squared_error_sum [60:19],
    // absolute_error_sum [86:61], argmax_match [87]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    localparam int IDX_W   = $clog2(MAX_ELEMENTS);
    localparam int SQA_W   = SQ_W + $clog2(MAX_ELEMENTS);
    localparam int ABSA_W  = MAG_W + $clog2(MAX_ELEMENTS);
    localparam logic [SQA_W-1:0] SQ_CAP =
        SQA_W'(DIFF_MAX * DIFF_MAX * 64'(MAX_ELEMENTS));
    localparam logic [ABSA_W-1:0] ABS_CAP =
        ABSA_W'(DIFF_MAX * 64'(MAX_ELEMENTS));
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ELEMENTS - 1);

    // input stage
    logic    s1_valid_reg;
    sample_t s1_pred_reg;
    sample_t s1_label_reg;
    logic    s1_last_reg;

    // compare stage
    logic    s2_valid_reg;
    stage_t  s2_reg;
    stage_t  s2_next;

    // output stage
    logic                  out_valid_reg;
    diff_t                 out_diff_reg;
    sign_t                 out_sign_reg;
    logic                  out_last_reg;
    logic [SQ_OUT_W-1:0]   out_sq_reg;
    logic [ABS_OUT_W-1:0]  out_abs_reg;
    logic                  out_match_reg;

    // running vector state
    logic [IDX_W-1:0]  idx_reg,        idx_next;
    sample_t           best_pred_reg,  best_pred_next;
    logic [IDX_W-1:0]  best_pidx_reg,  best_pidx_next;
    sample_t           best_label_reg, best_label_next;
    logic [IDX_W-1:0]  best_lidx_reg,  best_lidx_next;
    logic [SQA_W-1:0]  sq_acc_reg,     sq_acc_next;
    logic [ABSA_W-1:0] abs_acc_reg,    abs_acc_next;

    logic ready_out;
    logic ready_s2;
    logic s_accept;
    logic move_12;
    logic move_2o;

    diff_t            diff;
    logic [DIFF_W-1:0] diff_neg;
    logic [MAG_W-1:0] mag;
    logic             first_elem;
    logic             take_pred;
    logic             take_label;

    logic [SQA_W:0]    sq_sum;
    logic [ABSA_W:0]   abs_sum;
    logic [SQA_W-1:0]  sq_total;
    logic [ABSA_W-1:0] abs_total;

    assign ready_out = !out_valid_reg || m_tready;
    assign ready_s2  = !s2_valid_reg || ready_out;
    assign s_tready  = !s1_valid_reg || ready_s2;
    assign s_accept  = s_tvalid && s_tready;
    assign move_12   = s1_valid_reg && ready_s2;
    assign move_2o   = s2_valid_reg && ready_out;

    // difference, magnitude, sign and argmax tracking
    always_comb
    begin
        diff     = DIFF_W'(s1_pred_reg) - DIFF_W'(s1_label_reg);
        diff_neg = -diff;
        mag      = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

        first_elem = (idx_reg == '0);
        take_pred  = first_elem || (s1_pred_reg > best_pred_reg);
        take_label = first_elem || (s1_label_reg > best_label_reg);

        best_pred_next  = take_pred  ? s1_pred_reg  : best_pred_reg;
        best_pidx_next  = take_pred  ? idx_reg      : best_pidx_reg;
        best_label_next = take_label ? s1_label_reg : best_label_reg;
        best_lidx_next  = take_label ? idx_reg      : best_lidx_reg;

        s2_next.difference = diff;
        priority if (s1_pred_reg < s1_label_reg)
            s2_next.sign_compare = SIGN_LESS;
        else if (s1_pred_reg > s1_label_reg)
            s2_next.sign_compare = SIGN_GREATER;
        else
            s2_next.sign_compare = SIGN_EQUAL;
        s2_next.magnitude    = mag;
        s2_next.square       = SQ_W'(mag) * SQ_W'(mag);
        s2_next.last         = s1_last_reg;
        s2_next.argmax_match = (best_pidx_next == best_lidx_next);

        if (s1_last_reg)
        begin
            idx_next        = '0;
            best_pred_next  = '0;
            best_pidx_next  = '0;
            best_label_next = '0;
            best_lidx_next  = '0;
        end
        else if (idx_reg < IDX_LAST)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    // saturating accumulators
    always_comb
    begin
        sq_sum    = {1'b0, sq_acc_reg} + (SQA_W + 1)'(s2_reg.square);
        abs_sum   = {1'b0, abs_acc_reg} + (ABSA_W + 1)'(s2_reg.magnitude);
        sq_total  = (sq_sum > {1'b0, SQ_CAP}) ? SQ_CAP : sq_sum[SQA_W-1:0];
        abs_total = (abs_sum > {1'b0, ABS_CAP}) ? ABS_CAP : abs_sum[ABSA_W-1:0];
        sq_acc_next  = s2_reg.last ? '0 : sq_total;
        abs_acc_next = s2_reg.last ? '0 : abs_total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            best_pred_reg  <= '0;
            best_pidx_reg  <= '0;
            best_label_reg <= '0;
            best_lidx_reg  <= '0;
            sq_acc_reg     <= '0;
            abs_acc_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (ready_s2)
                s2_valid_reg <= s1_valid_reg;
            if (ready_out)
                out_valid_reg <= s2_valid_reg;
            if (move_12)
            begin
                idx_reg        <= idx_next;
                best_pred_reg  <= best_pred_next;
                best_pidx_reg  <= best_pidx_next;
                best_label_reg <= best_label_next;
                best_lidx_reg  <= best_lidx_next;
            end
            if (move_2o)
            begin
                sq_acc_reg  <= sq_acc_next;
                abs_acc_reg <= abs_acc_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_pred_reg  <= s_tdata[SAMPLE_W-1:0];
            s1_label_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            s1_last_reg  <= s_tlast;
        end
        if (move_12)
            s2_reg <= s2_next;
        if (move_2o)
        begin
            out_diff_reg  <= s2_reg.difference;
            out_sign_reg  <= s2_reg.sign_compare;
            out_last_reg  <= s2_reg.last;
            out_sq_reg    <= s2_reg.last ? SQ_OUT_W'(sq_total) : '0;
            out_abs_reg   <= s2_reg.last ? ABS_OUT_W'(abs_total) : '0;
            out_match_reg <= s2_reg.last && s2_reg.argmax_match;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_match_reg, out_abs_reg, out_sq_reg, out_sign_reg, out_diff_reg};

    // running sums never pass their caps
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_acc_reg <= SQ_CAP && abs_acc_reg <= ABS_CAP)
    else $error("accumulator above cap");

    // index saturates at the last slot
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_LAST)
    else $error("element index out of range");

    // a last request clears the index and argmax state
    assert property (@(posedge clk) disable iff (!rst_n)
        move_12 && s1_last_reg |=> idx_reg == '0 && best_pidx_reg == '0
                                   && best_lidx_reg == '0)
    else $error("vector state not cleared after last request");

    // the accumulators clear when the last request leaves for the output
    assert property (@(posedge clk) disable iff (!rst_n)
        move_2o && s2_reg.last |=> sq_acc_reg == '0 && abs_acc_reg == '0)
    else $error("accumulators not cleared after last request");

    // totals only appear on the last result of a vector
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> out_sq_reg == '0 && out_abs_reg == '0
                                           && !out_match_reg)
    else $error("totals on a result that is not last");

endmodule

`default_nettype wire
